// ----- rtl/psr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_pkg
// Constants, types and the control store of the page slot replacement block.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int SLOTS      = 5;
  localparam int PAGE_BITS  = 9;
  localparam int IDX_BITS   = $clog2(SLOTS);
  localparam int SIDX_BITS  = 3;
  localparam int PROT_BITS  = 4;
  localparam logic [PROT_BITS-1:0] PROT_RESET = 4'd2;

  localparam int IN_TDATA_W  = ((2 * PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PAGE_BITS + SIDX_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 4;

  // tuser bit positions of the result flags
  localparam int FLAG_HIT   = 0;
  localparam int FLAG_TOOK  = 1;
  localparam int FLAG_EVICT = 2;
  localparam int FLAG_NOV   = 3;

  localparam int STEP_BITS = 2;
  localparam logic [STEP_BITS-1:0] STEP_WAIT   = 2'd0;
  localparam logic [STEP_BITS-1:0] STEP_SCAN   = 2'd1;
  localparam logic [STEP_BITS-1:0] STEP_DECIDE = 2'd2;

  typedef enum logic [1:0] {
    COND_IN_VALID,
    COND_SCAN_LAST,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic                 accept_in;
    logic                 scan;
    logic                 decide;
    cond_t                cond;
    logic [STEP_BITS-1:0] jump;
  } ucode_t;

  // control store: each step holds until its condition is met, then jumps
  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ucode_t w;
    unique case (step)
      STEP_WAIT:   w = '{accept_in: 1'b1, scan: 1'b0, decide: 1'b0,
                         cond: COND_IN_VALID, jump: STEP_SCAN};
      STEP_SCAN:   w = '{accept_in: 1'b0, scan: 1'b1, decide: 1'b0,
                         cond: COND_SCAN_LAST, jump: STEP_DECIDE};
      STEP_DECIDE: w = '{accept_in: 1'b0, scan: 1'b0, decide: 1'b1,
                         cond: COND_OUT_FREE, jump: STEP_WAIT};
      default:     w = '{accept_in: 1'b0, scan: 1'b0, decide: 1'b0,
                         cond: COND_OUT_FREE, jump: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/page_slot_replacement.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_slot_replacement
// Ring of page buffer slots with hit lookup, empty fill and farthest eviction.
// ----------------------------------------------------------------------------
// a new input word is taken only once the result of the last one is registered;
//   the scan step reads one slot per cycle through the single slot read mux
// reset: all slots empty, ring head 0, protect distance 2, no result pending
module page_slot_replacement (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psr_pkg::PROT_BITS-1:0]       cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // requested_page, displayed_page, zero pad
  input  logic [psr_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // victim_page, slot_index, zero pad
  output logic [psr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // hit, took_empty, evicted, no_victim
  output logic [psr_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  localparam int PB = psr_pkg::PAGE_BITS;
  localparam int IB = psr_pkg::IDX_BITS;
  localparam logic [IB-1:0] LAST_IDX = IB'(psr_pkg::SLOTS - 1);

  logic [psr_pkg::STEP_BITS-1:0] step, step_next;
  psr_pkg::ucode_t               uw;
  logic                          cond_met;

  logic [PB-1:0]                 slot_page [psr_pkg::SLOTS];
  logic [IB-1:0]                 ring_head;
  logic [psr_pkg::PROT_BITS-1:0] protect_distance;

  logic [PB-1:0] req, dis;
  logic [IB-1:0] ptr, cnt;
  logic          have_hit, have_empty, have_best;
  logic [IB-1:0] hit_pos, empty_pos, best_pos;
  logic [PB-1:0] best, best_page;

  logic [PB-1:0] pg, gap, in_req;
  logic          out_free;

  logic [psr_pkg::OUT_TDATA_W-1:0] out_data;
  logic [psr_pkg::OUT_TUSER_W-1:0] out_user;

  assign uw       = psr_pkg::ucode_rom(step);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = uw.accept_in;
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (uw.cond)
      psr_pkg::COND_IN_VALID:  cond_met = s_tvalid;
      psr_pkg::COND_SCAN_LAST: cond_met = (cnt == LAST_IDX);
      psr_pkg::COND_OUT_FREE:  cond_met = out_free;
      default:                 cond_met = 1'b0;
    endcase
    step_next = cond_met ? uw.jump : step;
  end

  assign in_req = (s_tdata[PB-1:0] == '0) ? PB'(1) : s_tdata[PB-1:0];
  assign pg     = slot_page[ptr];
  assign gap    = (pg > dis) ? (pg - dis) : (dis - pg);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= psr_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protect_distance <= psr_pkg::PROT_RESET;
    end else if (cfg_valid) begin
      protect_distance <= cfg_data;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (uw.accept_in && s_tvalid) begin
      req        <= in_req;
      dis        <= s_tdata[2*PB-1:PB];
      ptr        <= ring_head;
      cnt        <= '0;
      have_hit   <= 1'b0;
      have_empty <= 1'b0;
      have_best  <= 1'b0;
    end else if (uw.scan) begin
      if (pg == req) begin
        have_hit <= 1'b1;
        hit_pos  <= ptr;
      end
      if (pg == '0) begin
        if (!have_empty) begin
          have_empty <= 1'b1;
          empty_pos  <= ptr;
        end
      end else if (!have_empty && gap > PB'(protect_distance)
                   && (!have_best || gap > best)) begin
        // only slots ahead of the first empty one compete
        have_best <= 1'b1;
        best      <= gap;
        best_pos  <= ptr;
        best_page <= pg;
      end
      ptr <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
      cnt <= cnt + 1'b1;
    end
  end

  // slot store and ring head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psr_pkg::SLOTS; i++) begin
        slot_page[i] <= '0;
      end
      ring_head <= '0;
    end else if (uw.decide && out_free && !have_hit) begin
      if (have_empty) begin
        slot_page[empty_pos] <= req;
        ring_head            <= empty_pos;
      end else if (have_best) begin
        slot_page[best_pos] <= req;
      end
    end
  end

  // result word
  always_comb begin
    out_data = '0;
    out_user = '0;
    priority if (have_hit) begin
      out_user[psr_pkg::FLAG_HIT] = 1'b1;
      out_data[PB +: psr_pkg::SIDX_BITS] = psr_pkg::SIDX_BITS'(hit_pos);
    end else if (have_empty) begin
      out_user[psr_pkg::FLAG_TOOK] = 1'b1;
      out_data[PB +: psr_pkg::SIDX_BITS] = psr_pkg::SIDX_BITS'(empty_pos);
    end else if (have_best) begin
      out_user[psr_pkg::FLAG_EVICT] = 1'b1;
      out_data[PB-1:0] = best_page;
      out_data[PB +: psr_pkg::SIDX_BITS] = psr_pkg::SIDX_BITS'(best_pos);
    end else begin
      out_user[psr_pkg::FLAG_NOV] = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uw.decide && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.decide && out_free) begin
      m_tdata <= out_data;
      m_tuser <= out_user;
    end
  end

endmodule

// ----- rtl/psr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_checker
// Port-level checks of the page slot replacement block, bound to the top.
// ----------------------------------------------------------------------------
module psr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [psr_pkg::PROT_BITS-1:0]       cfg_data,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [psr_pkg::IN_TDATA_W-1:0]      s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [psr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input logic [psr_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  localparam int PB = psr_pkg::PAGE_BITS;

  // every result carries exactly one outcome flag
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser))
    else $error("result flags not one-hot");

  // no victim and hit leave the victim page clear
  a_nov_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[psr_pkg::FLAG_NOV] || m_tuser[psr_pkg::FLAG_HIT]))
    |-> (m_tdata[PB-1:0] == '0))
    else $error("victim page set without eviction");

  // a word starts a scan, so the input side closes right after
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken during scan");

  // reset drops any pending result
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind page_slot_replacement psr_checker u_psr_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page slot replacement block: a short table of
// hand-picked requests, then random request streams under several protect
// distances, results checked against the table or a cycle-free ring model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PB          = psr_pkg::PAGE_BITS;
  localparam int SB          = psr_pkg::SIDX_BITS;
  localparam int PLAN_ROWS   = 15;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          hit;
    logic          took;
    logic          evict;
    logic          nov;
    logic [PB-1:0] victim;
    logic [SB-1:0] slot;
  } page_result_t;

  typedef struct packed {
    logic [PB-1:0] req;
    logic [PB-1:0] disp;
    logic          typed;
    page_result_t  want;
  } page_row_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [psr_pkg::PROT_BITS-1:0]       cfg_data;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [psr_pkg::IN_TDATA_W-1:0]      s_tdata;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [psr_pkg::OUT_TDATA_W-1:0]     m_tdata;
  logic [psr_pkg::OUT_TUSER_W-1:0]     m_tuser;

  // model of the slot ring
  int held_page [psr_pkg::SLOTS];
  int ring_head;
  int protect_dist;

  page_result_t pending_results[$];
  int send_idle_pct;
  int recv_idle_pct;
  int cluster_base;
  int sent_count;
  int error_count = 0;
  int cycle_count = 0;
  int tally_hit = 0;
  int tally_fill = 0;
  int tally_evict = 0;
  int tally_none = 0;

  // req, disp, typed, hit, took, evict, nov, victim, slot
  page_row_t plan [PLAN_ROWS] = '{
    {9'd0,   9'd0,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0, 3'd0},  // page zero, held as page 1, into slot 0
    {9'd1,   9'd511, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 9'd0, 3'd0},  // hit on page 1
    {9'd511, 9'd511, 1'b0, 16'd0},
    {9'd2,   9'd0,   1'b0, 16'd0},
    {9'd3,   9'd3,   1'b0, 16'd0},
    {9'd4,   9'd4,   1'b0, 16'd0},                               // ring now full
    {9'd5,   9'd3,   1'b0, 16'd0},                               // far page 511 goes
    {9'd6,   9'd3,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 9'd0, 3'd0},  // all pages protected
    {9'd0,   9'd300, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 9'd0, 3'd0},  // page zero as hit
    {9'd511, 9'd0,   1'b0, 16'd0},
    {9'd256, 9'd257, 1'b0, 16'd0},
    {9'd300, 9'd170, 1'b0, 16'd0},
    {9'd6,   9'd6,   1'b0, 16'd0},
    {9'd0,   9'd511, 1'b0, 16'd0},
    {9'd510, 9'd1,   1'b0, 16'd0}
  };

  page_slot_replacement u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // expected outcome of one request; updates the ring model
  function automatic page_result_t place_page(input logic [PB-1:0] req_in,
                                              input logic [PB-1:0] disp_in);
    page_result_t r;
    int req, disp, pos, gap, best, best_slot;
    bit have_best, done;
    r = '0;
    req = (req_in == 0) ? 1 : int'(req_in);
    disp = int'(disp_in);
    have_best = 0;
    done = 0;
    best = 0;
    best_slot = 0;
    for (int i = 0; i < psr_pkg::SLOTS; i++) begin
      if (!done && held_page[i] == req) begin
        r.hit = 1'b1;
        r.slot = SB'(i);
        done = 1;
      end
    end
    pos = ring_head % psr_pkg::SLOTS;
    for (int i = 0; i < psr_pkg::SLOTS; i++) begin
      if (!done) begin
        if (held_page[pos] == 0) begin
          held_page[pos] = req;
          ring_head = pos;
          r.took = 1'b1;
          r.slot = SB'(pos);
          done = 1;
        end else begin
          gap = (held_page[pos] > disp) ? held_page[pos] - disp : disp - held_page[pos];
          // strict compare keeps the first slot in ring order on a tie
          if (gap > protect_dist && (!have_best || gap > best)) begin
            best = gap;
            best_slot = pos;
            have_best = 1;
          end
          pos = (pos + 1) % psr_pkg::SLOTS;
        end
      end
    end
    if (!done) begin
      if (have_best) begin
        r.victim = PB'(held_page[best_slot]);
        held_page[best_slot] = req;
        r.evict = 1'b1;
        r.slot = SB'(best_slot);
      end else begin
        r.nov = 1'b1;
      end
    end
    return r;
  endfunction

  // caller stands at a rising edge; returns at the edge that took the word
  task automatic send_request(input logic [PB-1:0] req,
                              input logic [PB-1:0] disp,
                              input bit typed, input page_result_t want);
    page_result_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tdata  <= {{(psr_pkg::IN_TDATA_W - 2 * PB){1'b0}}, disp, req};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = place_page(req, disp);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_protect(input logic [psr_pkg::PROT_BITS-1:0] value);
    drain_results();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    protect_dist = int'(value);
  endtask

  task automatic send_random_requests(input int count);
    logic [PB-1:0] req, disp;
    int pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) cluster_base = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        // page already in the ring, or page 1 if the pick is empty
        req  = PB'(held_page[$urandom_range(0, psr_pkg::SLOTS - 1)]);
        disp = PB'($urandom);
      end else if (pick < 65) begin
        // pages bunched near the displayed page: ties and refusals
        req  = PB'(cluster_base + int'($urandom_range(0, 20)));
        disp = PB'(cluster_base + int'($urandom_range(0, 20)));
      end else if (pick < 69) begin
        req  = '0;
        disp = PB'($urandom);
      end else begin
        req  = PB'($urandom);
        disp = PB'($urandom);
      end
      send_request(req, disp, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    page_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit    = m_tuser[psr_pkg::FLAG_HIT];
      got.took   = m_tuser[psr_pkg::FLAG_TOOK];
      got.evict  = m_tuser[psr_pkg::FLAG_EVICT];
      got.nov    = m_tuser[psr_pkg::FLAG_NOV];
      got.victim = m_tdata[PB-1:0];
      got.slot   = m_tdata[PB+SB-1:PB];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result with none expected: hit=%0b took=%0b evict=%0b nov=%0b"
                 , $realtime, got.hit, got.took, got.evict, got.nov);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          $display({"%0t ns: mismatch expected hit=%0b took=%0b evict=%0b nov=%0b",
                    " victim=%0d slot=%0d"},
                   $realtime, want.hit, want.took, want.evict, want.nov, want.victim,
                   want.slot);
          $display({"%0t ns:            actual hit=%0b took=%0b evict=%0b nov=%0b",
                    " victim=%0d slot=%0d"},
                   $realtime, got.hit, got.took, got.evict, got.nov, got.victim,
                   got.slot);
        end
      end
      tally_hit   += got.hit;
      tally_fill  += got.took;
      tally_evict += got.evict;
      tally_none  += got.nov;
    end
  end

  initial begin
    page_row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < psr_pkg::SLOTS; i++) held_page[i] = 0;
    ring_head = 0;
    protect_dist = int'(psr_pkg::PROT_RESET);
    send_idle_pct = 15;
    recv_idle_pct = 60;
    cluster_base = $urandom;
    sent_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = plan[i];
      send_request(row.req, row.disp, row.typed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 5:    write_protect(ph == 0 ? 4'd0 : 4'($urandom_range(0, 15)));
        1, 3:    write_protect(4'd15);
        2:       write_protect(4'd9);
        default: write_protect(4'd1);
      endcase
      case (ph % 3)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      send_random_requests(PHASE_ITEMS);
    end

    drain_results();
    // catch any stray word past the last expected one
    repeat (psr_pkg::SLOTS + 4) @(posedge clk);

    $display("run covered %0d requests over the reset and %0d written protect distances",
             sent_count, PHASES);
    $display("outcomes seen: %0d hits, %0d fills, %0d evictions, %0d refusals",
             tally_hit, tally_fill, tally_evict, tally_none);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
